FILE: hw/rtl/scd_pkg.sv
package scd_pkg;

    // parser states
    typedef enum logic [3:0] {
        PS_TAG,
        PS_TXMAGIC,
        PS_WINDOW,
        PS_LENLO,
        PS_LENHI,
        PS_CONFIG,
        PS_PAYLOAD,
        PS_QCOUNT,
        PS_QBODY
    } t_pstate;

    // event codes on the result channel
    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_TX_BYTE     = 4'd1,
        EV_TX_LAST     = 4'd2,
        EV_CONFIG      = 4'd3,
        EV_SCAN        = 4'd4,
        EV_WINDOW      = 4'd5,
        EV_STATS       = 4'd6,
        EV_RESET       = 4'd7,
        EV_BAD_CFG_LEN = 4'd8,
        EV_BAD_TX_LEN  = 4'd9
    } t_event;

    // frame tag characters
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_X = 8'h58;

    localparam int          BODY_DEPTH    = 17;
    localparam int          BODY_IDX_W    = 5;
    localparam logic [31:0] SCAN_MAGIC    = 32'hFFFF_FFFF;
    localparam logic [31:0] MIN_DWELL     = 32'd50;
    localparam logic [14:0] DWELL_UNIT    = 15'd100;
    localparam logic [7:0]  GRID_DEFAULT  = 8'd16;
    localparam logic [15:0] CFG_LEN_SHORT = 16'd15;
    localparam logic [15:0] CFG_LEN_LONG  = 16'd17;
    localparam logic [13:0] WINDOW_LEN    = 14'd8;
    localparam logic [13:0] QBODY_KEEP    = 14'd8;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_byte;
        logic [13:0] length;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [4:0]  channel_count;
        logic [31:0] dwell_time;
        logic [7:0]  tx_power;
        logic [7:0]  role;
    } t_result;

endpackage

FILE: hw/rtl/serial_command_deframer.sv
// serial command deframer: takes one received serial byte per input beat and
// returns exactly one result beat for it, in order (event 0 when the byte
// finishes nothing). frames: 'T','X',len16,payload forwards each payload byte
// (the last one marked, with the length); 'C',len16,15 or 17 body bytes gives
// radio settings, or a grid scan when the frequency word is all ones; 'W' plus
// 8 bytes sets the slot window; 'Q',count,body requests a list scan; 'S' and
// 'X' request stats and reset. multi-byte words are little-endian. a byte can
// be accepted every cycle; each byte passes through the input register, then
// parse logic into the result register, and the result register frees in
// the same cycle it is taken, so throughput stays at one beat per cycle
// while the consumer keeps i_stall low.
module serial_command_deframer import scd_pkg::*; #(
    parameter int MAX_TX_LEN        = 12288,
    parameter int MAX_SCAN_CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [13:0] o_length,
    output logic [31:0] o_word_a,
    output logic [31:0] o_word_b,
    output logic [4:0]  o_channel_count,
    output logic [31:0] o_dwell_time,
    output logic [7:0]  o_tx_power,
    output logic [7:0]  o_role
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_out_free;
    logic       w_take;
    t_result    w_res;

    logic       r_out_valid;
    t_result    r_res;

    // result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    // parser consumes the held byte and advances its state on the same edge
    assign w_take     = w_in_valid && w_out_free;

    scd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_rx_byte),
        .i_take  (w_take),
        .o_stall (o_stall),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    scd_parser #(
        .MAX_TX_LEN        (MAX_TX_LEN),
        .MAX_SCAN_CHANNELS (MAX_SCAN_CHANNELS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_take),
        .i_byte  (w_in_byte),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_res     = r_res.event_res;
    assign o_data_byte     = r_res.data_byte;
    assign o_length        = r_res.length;
    assign o_word_a        = r_res.word_a;
    assign o_word_b        = r_res.word_b;
    assign o_channel_count = r_res.channel_count;
    assign o_dwell_time    = r_res.dwell_time;
    assign o_tx_power      = r_res.tx_power;
    assign o_role          = r_res.role;

endmodule

FILE: hw/rtl/scd_in_reg.sv
module scd_in_reg import scd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // holding a byte that the parser cannot take yet
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: hw/rtl/scd_parser.sv
module scd_parser import scd_pkg::*; #(
    parameter int MAX_TX_LEN        = 12288,
    parameter int MAX_SCAN_CHANNELS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_pstate     r_state, n_state;
    logic        r_is_tx, n_is_tx;
    logic [13:0] r_flen, n_flen;
    logic [13:0] r_bc, n_bc;
    logic [4:0]  r_sc, n_sc;
    logic [7:0]  r_body [BODY_DEPTH];

    logic                  w_wr_en;
    logic [BODY_IDX_W-1:0] w_idx;
    logic [7:0]            w_view [BODY_DEPTH];
    logic [13:0]           w_bc_inc;
    logic [15:0]           w_full;
    logic [6:0]            w_need;
    logic [31:0]           w_freq;
    logic [14:0]           w_grid_prod;
    logic [31:0]           w_grid_dwell;
    logic [31:0]           w_list_dwell;
    logic [7:0]            w_grid_cnt;

    assign w_idx    = r_bc[BODY_IDX_W-1:0];
    assign w_bc_inc = r_bc + 14'd1;
    assign w_full   = {i_byte, r_flen[7:0]};
    assign w_need   = {r_sc, 2'b00} + 7'd4;

    // body bytes are stored in window, config and the head of a list scan
    always_comb begin
        w_wr_en = 1'b0;
        case (r_state)
            PS_WINDOW, PS_CONFIG: w_wr_en = 1'b1;
            PS_QBODY:             w_wr_en = r_bc < QBODY_KEEP;
            default:              w_wr_en = 1'b0;
        endcase
        if (r_bc >= 14'(BODY_DEPTH)) begin
            w_wr_en = 1'b0;
        end
    end

    // body as it stands after this byte
    always_comb begin
        for (int k = 0; k < BODY_DEPTH; k++) begin
            w_view[k] = (w_wr_en && w_idx == BODY_IDX_W'(k)) ? i_byte : r_body[k];
        end
    end

    assign w_freq = {w_view[3], w_view[2], w_view[1], w_view[0]};

    // grid scan count and dwell
    always_comb begin
        w_grid_cnt = w_view[8];
        if (w_grid_cnt == 8'd0) begin
            w_grid_cnt = GRID_DEFAULT;
        end
        if (w_grid_cnt > 8'(MAX_SCAN_CHANNELS)) begin
            w_grid_cnt = 8'(MAX_SCAN_CHANNELS);
        end
    end

    assign w_grid_prod  = {7'd0, w_view[9]} * DWELL_UNIT;
    assign w_grid_dwell = ({17'd0, w_grid_prod} < MIN_DWELL) ? MIN_DWELL
                                                            : {17'd0, w_grid_prod};
    assign w_list_dwell = (w_freq < MIN_DWELL) ? MIN_DWELL : w_freq;

    always_comb begin
        n_state = r_state;
        n_is_tx = r_is_tx;
        n_flen  = r_flen;
        n_bc    = r_bc;
        n_sc    = r_sc;
        o_res   = '0;
        case (r_state)
            PS_TAG: begin
                n_bc = '0;
                if (i_byte == CH_T) begin
                    n_is_tx = 1'b1;
                    n_state = PS_TXMAGIC;
                end else if (i_byte == CH_W) begin
                    n_state = PS_WINDOW;
                end else if (i_byte == CH_C) begin
                    n_is_tx = 1'b0;
                    n_state = PS_LENLO;
                end else if (i_byte == CH_S) begin
                    o_res.event_res = EV_STATS;
                end else if (i_byte == CH_Q) begin
                    n_state = PS_QCOUNT;
                end else if (i_byte == CH_X) begin
                    o_res.event_res = EV_RESET;
                end
            end
            PS_TXMAGIC: begin
                n_state = (i_byte == CH_X) ? PS_LENLO : PS_TAG;
            end
            PS_WINDOW: begin
                n_bc = w_bc_inc;
                if (w_bc_inc >= WINDOW_LEN) begin
                    o_res.event_res = EV_WINDOW;
                    o_res.word_a    = w_freq;
                    o_res.word_b    = {w_view[7], w_view[6], w_view[5], w_view[4]};
                    n_state         = PS_TAG;
                    n_bc            = '0;
                end
            end
            PS_LENLO: begin
                n_flen  = {6'd0, i_byte};
                n_state = PS_LENHI;
            end
            PS_LENHI: begin
                n_bc = '0;
                if (!r_is_tx) begin
                    if (w_full != CFG_LEN_SHORT && w_full != CFG_LEN_LONG) begin
                        o_res.event_res = EV_BAD_CFG_LEN;
                        n_state         = PS_TAG;
                    end else begin
                        n_flen  = w_full[13:0];
                        n_state = PS_CONFIG;
                    end
                end else begin
                    if (w_full == 16'd0 || w_full > 16'(MAX_TX_LEN)) begin
                        o_res.event_res = EV_BAD_TX_LEN;
                        n_state         = PS_TAG;
                    end else begin
                        n_flen  = w_full[13:0];
                        n_state = PS_PAYLOAD;
                    end
                end
            end
            PS_CONFIG: begin
                n_bc = w_bc_inc;
                if (w_bc_inc >= r_flen) begin
                    if (w_freq == SCAN_MAGIC) begin
                        n_sc                  = w_grid_cnt[4:0];
                        o_res.event_res       = EV_SCAN;
                        o_res.word_a          = {w_view[13], w_view[12],
                                                 w_view[11], w_view[10]};
                        o_res.word_b          = {w_view[7], w_view[6],
                                                 w_view[5], w_view[4]};
                        o_res.channel_count   = w_grid_cnt[4:0];
                        o_res.dwell_time      = w_grid_dwell;
                    end else begin
                        o_res.event_res = EV_CONFIG;
                        o_res.word_a    = w_freq;
                        o_res.tx_power  = w_view[9];
                        o_res.role      = w_view[14];
                    end
                    n_state = PS_TAG;
                    n_bc    = '0;
                end
            end
            PS_PAYLOAD: begin
                o_res.data_byte = i_byte;
                n_bc            = w_bc_inc;
                if (w_bc_inc >= r_flen) begin
                    o_res.event_res = EV_TX_LAST;
                    o_res.length    = r_flen;
                    n_state         = PS_TAG;
                    n_bc            = '0;
                end else begin
                    o_res.event_res = EV_TX_BYTE;
                end
            end
            PS_QCOUNT: begin
                n_bc = '0;
                if (i_byte >= 8'd1 && i_byte <= 8'(MAX_SCAN_CHANNELS)) begin
                    n_sc    = i_byte[4:0];
                    n_state = PS_QBODY;
                end else begin
                    n_state = PS_TAG;
                end
            end
            PS_QBODY: begin
                n_bc = w_bc_inc;
                if (w_bc_inc >= {7'd0, w_need}) begin
                    o_res.event_res     = EV_SCAN;
                    o_res.word_a        = {w_view[7], w_view[6], w_view[5], w_view[4]};
                    o_res.channel_count = r_sc;
                    o_res.dwell_time    = w_list_dwell;
                    n_state             = PS_TAG;
                    n_bc                = '0;
                end
            end
            default: begin
                n_state = PS_TAG;
                n_bc    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_TAG;
            r_is_tx <= 1'b0;
            r_flen  <= '0;
            r_bc    <= '0;
            r_sc    <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_is_tx <= n_is_tx;
            r_flen  <= n_flen;
            r_bc    <= n_bc;
            r_sc    <= n_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_wr_en) begin
            r_body[w_idx] <= i_byte;
        end
    end

endmodule
